// ===== design/pcsc_pkg.sv =====
package pcsc_pkg;

  // Chunk parsing phases
  localparam logic [2:0] PH_LEN     = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_CRC     = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  // End-of-chunk status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_CRC    = 2'd1;
  localparam logic [1:0] ST_BAD_LEN    = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [31:0] CRC_POLY      = 32'hedb88320;
  localparam logic [31:0] CRC_INIT      = 32'hffffffff;
  localparam logic [30:0] MAX_LEN_RESET = 31'h7fffffff;
  localparam logic [31:0] BIT_ANCILLARY = 32'h20000000;
  localparam logic [31:0] BIT_PRIVATE   = 32'h00200000;
  localparam logic [31:0] BIT_RESERVED  = 32'h00002000;
  localparam logic [31:0] BIT_SAFE_COPY = 32'h00000020;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } pcsc_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [30:0] chunk_length;
    logic [31:0] chunk_type;
    logic        type_valid;
    logic        is_critical;
    logic        is_private;
    logic        is_reserved;
    logic        is_safe_to_copy;
  } pcsc_out_t;

  // Reflected CRC-32 update over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  // Build an end-of-chunk status beat from what is known so far
  function automatic pcsc_out_t mk_status(input logic [1:0] st, input logic have_len,
                                          input logic have_type, input logic [31:0] len,
                                          input logic [31:0] typ);
    pcsc_out_t   r;
    logic [31:0] t;
    t = have_type ? typ : 32'd0;
    r.kind            = KIND_STATUS;
    r.data_byte       = 8'd0;
    r.status          = st;
    r.chunk_length    = have_len ? len[30:0] : 31'd0;
    r.chunk_type      = t;
    r.type_valid      = have_type && is_letter(t[31:24]) && is_letter(t[23:16]) &&
                        is_letter(t[15:8]) && is_letter(t[7:0]);
    r.is_critical     = have_type && ((t & BIT_ANCILLARY) == 32'd0);
    r.is_private      = (t & BIT_PRIVATE) != 32'd0;
    r.is_reserved     = (t & BIT_RESERVED) != 32'd0;
    r.is_safe_to_copy = (t & BIT_SAFE_COPY) != 32'd0;
    return r;
  endfunction

endpackage

// ===== design/pcsc_parser.sv =====
module pcsc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pcsc_pkg::pcsc_in_t  item,
  input  logic [30:0]         max_length,
  output logic                res_valid,
  output pcsc_pkg::pcsc_out_t res
);
  import pcsc_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [30:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;

  logic        restart;
  logic [7:0]  b;
  logic        eos;
  logic [30:0] cnt_inc;
  logic [31:0] len_sh;
  logic [31:0] type_sh;
  logic [31:0] crc_upd;
  logic [31:0] rcrc_sh;
  logic        last4;

  assign b       = item.in_byte;
  assign eos     = item.stream_end;
  assign cnt_inc = cnt_r + 31'd1;
  assign len_sh  = {len_r[23:0], b};
  assign type_sh = {type_r[23:0], b};
  assign rcrc_sh = {rcrc_r[23:0], b};
  assign crc_upd = crc_byte(crc_r, b);
  assign last4   = cnt_r >= 31'd3;

  // Next chunk state and the result of the current beat
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    restart   = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      PH_LEN: begin
        len_nxt = len_sh;
        cnt_nxt = cnt_inc;
        if (last4) begin
          cnt_nxt = 31'd0;
          if (len_sh > {1'b0, max_length}) begin
            res_valid = 1'b1;
            res       = mk_status(ST_BAD_LEN, 1'b1, 1'b0, len_sh, type_r);
            if (eos) restart = 1'b1;
            else phase_nxt = PH_DISCARD;
          end else begin
            phase_nxt = PH_TYPE;
            if (eos) begin
              res_valid = 1'b1;
              res       = mk_status(ST_INCOMPLETE, 1'b1, 1'b0, len_sh, type_r);
              restart   = 1'b1;
            end
          end
        end else if (eos) begin
          res_valid = 1'b1;
          res       = mk_status(ST_INCOMPLETE, 1'b0, 1'b0, len_sh, type_r);
          restart   = 1'b1;
        end
      end
      PH_TYPE: begin
        type_nxt = type_sh;
        crc_nxt  = crc_upd;
        cnt_nxt  = cnt_inc;
        if (last4) begin
          phase_nxt = (len_r == 32'd0) ? PH_CRC : PH_DATA;
          cnt_nxt   = 31'd0;
        end
        if (eos) begin
          res_valid = 1'b1;
          res       = mk_status(ST_INCOMPLETE, 1'b1, last4, len_r, type_sh);
          restart   = 1'b1;
        end
      end
      PH_DATA: begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if ({1'b0, cnt_inc} >= len_r) begin
          phase_nxt = PH_CRC;
          cnt_nxt   = 31'd0;
        end
        res_valid = 1'b1;
        if (eos) begin
          res     = mk_status(ST_INCOMPLETE, 1'b1, 1'b1, len_r, type_r);
          restart = 1'b1;
        end else begin
          res.kind      = KIND_DATA;
          res.data_byte = b;
        end
      end
      PH_CRC: begin
        rcrc_nxt = rcrc_sh;
        cnt_nxt  = cnt_inc;
        if (last4) begin
          res_valid = 1'b1;
          res       = mk_status((rcrc_sh == ~crc_r) ? ST_OK : ST_BAD_CRC,
                                1'b1, 1'b1, len_r, type_r);
          restart   = 1'b1;
        end else if (eos) begin
          res_valid = 1'b1;
          res       = mk_status(ST_INCOMPLETE, 1'b1, 1'b1, len_r, type_r);
          restart   = 1'b1;
        end
      end
      PH_DISCARD: begin
        if (eos) restart = 1'b1;
      end
      default: begin
        restart = 1'b1;
      end
    endcase
    // Drop back to the start of a fresh chunk
    if (restart) begin
      phase_nxt = PH_LEN;
      cnt_nxt   = 31'd0;
      len_nxt   = 32'd0;
      type_nxt  = 32'd0;
      crc_nxt   = CRC_INIT;
      rcrc_nxt  = 32'd0;
    end
  end

  // Advance chunk state on each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      cnt_r   <= 31'd0;
      len_r   <= 32'd0;
      type_r  <= 32'd0;
      crc_r   <= CRC_INIT;
      rcrc_r  <= 32'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

endmodule

// ===== design/png_chunk_stream_checker.sv =====
// PNG chunk stream checker. Takes one stream byte per beat and sustains one byte per
// clock cycle while no result is stalled; each byte passes the input register, then the
// result register, and the per-byte CRC-32 update between them sets the clock limit.
// Data bytes come out as kind 0 beats; each chunk closes with one status beat (ok, bad
// CRC, length over max_length, or incomplete when stream_end cuts it short). After a
// length over the limit, bytes are dropped up to the stream_end byte. The user must
// write max_length through the cfg port only while no bytes are in flight (not enforced).
module png_chunk_stream_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcsc_pkg::pcsc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcsc_pkg::pcsc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [30:0]         cfg_max_length
);
  import pcsc_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  pcsc_in_t    in_data_r;
  logic        out_vld_r, out_vld_nxt;
  pcsc_out_t   out_data_r;
  logic [30:0] max_len_r;

  logic        res_valid;
  pcsc_out_t   res;
  logic        out_free;
  logic        adv;
  logic        in_acc;

  // Move the held beat on when it makes no result or the result register frees up
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = in_vld_r && (out_free || !res_valid);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  pcsc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .item       (in_data_r),
    .max_length (max_len_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Input register
  assign in_vld_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_data_r <= in_data;
  end

  // Result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv && res_valid) out_vld_nxt = 1'b1;
    else if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) out_data_r <= res;
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_length;
    end
  end

  // Never overwrite a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_valid |-> out_free)
    else $error("result register overwritten while stalled");

  // Data beats carry no status
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_DATA) |-> (out_data.status == ST_OK) &&
    (out_data.chunk_type == 32'd0) && (out_data.chunk_length == 31'd0))
    else $error("data beat with status fields set");

  // Bad length is reported before any type byte
  a_bad_len_no_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_STATUS) && (out_data.status == ST_BAD_LEN) |->
    (out_data.chunk_type == 32'd0) && !out_data.type_valid && !out_data.is_critical)
    else $error("bad length status carries a type");

  // A held beat that cannot move stalls the input
  a_hold_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && res_valid && out_vld_r && out_stall |=> in_vld_r)
    else $error("input beat lost while output stalled");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pcsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 280;

  // Track chunk parsing of the byte stream and hold the beats it must produce
  class chunk_scoreboard;
    pcsc_out_t   expected_q[$];
    int unsigned mismatches;
    logic [30:0] len_limit;
    logic [2:0]  ph;
    logic [30:0] cnt;
    logic [31:0] len_acc;
    logic [31:0] type_acc;
    logic [31:0] crc_acc;
    logic [31:0] crc_rx;

    function new();
      mismatches = 0;
      len_limit  = MAX_LEN_RESET;
      clear_chunk();
    endfunction

    // Reflected CRC-32, one bit at a time
    static function logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc;
      for (int k = 0; k < 8; k++) begin
        if (c[0] ^ b[k]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    static function bit letter_ok(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function void clear_chunk();
      ph       = PH_LEN;
      cnt      = '0;
      len_acc  = '0;
      type_acc = '0;
      crc_acc  = CRC_INIT;
      crc_rx   = '0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Build the end-of-chunk beat from the fields known so far
    function pcsc_out_t end_beat(logic [1:0] st, bit have_len, bit have_type);
      pcsc_out_t   r;
      logic [31:0] t;
      t = have_type ? type_acc : 32'd0;
      r = '0;
      r.kind            = KIND_STATUS;
      r.status          = st;
      r.chunk_length    = have_len ? len_acc[30:0] : 31'd0;
      r.chunk_type      = t;
      r.type_valid      = have_type && letter_ok(t[31:24]) && letter_ok(t[23:16]) &&
                          letter_ok(t[15:8]) && letter_ok(t[7:0]);
      r.is_critical     = have_type && !t[29];
      r.is_private      = t[21];
      r.is_reserved     = t[13];
      r.is_safe_to_copy = t[5];
      return r;
    endfunction

    // Advance the chunk parser by one accepted byte
    function void note_byte(pcsc_in_t it);
      logic [7:0] b;
      bit         fin;
      bit         have_type;
      pcsc_out_t  d;
      b   = it.in_byte;
      fin = it.stream_end;
      case (ph)
        PH_LEN: begin
          len_acc = {len_acc[23:0], b};
          cnt     = cnt + 31'd1;
          if (cnt >= 4) begin
            if (len_acc > {1'b0, len_limit}) begin
              expected_q.push_back(end_beat(ST_BAD_LEN, 1'b1, 1'b0));
              if (fin) begin
                clear_chunk();
              end else begin
                ph  = PH_DISCARD;
                cnt = '0;
              end
            end else begin
              ph  = PH_TYPE;
              cnt = '0;
              if (fin) begin
                expected_q.push_back(end_beat(ST_INCOMPLETE, 1'b1, 1'b0));
                clear_chunk();
              end
            end
          end else if (fin) begin
            expected_q.push_back(end_beat(ST_INCOMPLETE, 1'b0, 1'b0));
            clear_chunk();
          end
        end
        PH_TYPE: begin
          type_acc  = {type_acc[23:0], b};
          crc_acc   = crc32_update(crc_acc, b);
          cnt       = cnt + 31'd1;
          have_type = 1'b0;
          if (cnt >= 4) begin
            have_type = 1'b1;
            ph        = (len_acc == 0) ? PH_CRC : PH_DATA;
            cnt       = '0;
          end
          if (fin) begin
            expected_q.push_back(end_beat(ST_INCOMPLETE, 1'b1, have_type));
            clear_chunk();
          end
        end
        PH_DATA: begin
          crc_acc = crc32_update(crc_acc, b);
          cnt     = cnt + 31'd1;
          if ({1'b0, cnt} >= len_acc) begin
            ph  = PH_CRC;
            cnt = '0;
          end
          if (fin) begin
            expected_q.push_back(end_beat(ST_INCOMPLETE, 1'b1, 1'b1));
            clear_chunk();
          end else begin
            d           = '0;
            d.kind      = KIND_DATA;
            d.data_byte = b;
            expected_q.push_back(d);
          end
        end
        PH_CRC: begin
          crc_rx = {crc_rx[23:0], b};
          cnt    = cnt + 31'd1;
          if (cnt >= 4) begin
            expected_q.push_back(end_beat((crc_rx == ~crc_acc) ? ST_OK : ST_BAD_CRC,
                                          1'b1, 1'b1));
            clear_chunk();
          end else if (fin) begin
            expected_q.push_back(end_beat(ST_INCOMPLETE, 1'b1, 1'b1));
            clear_chunk();
          end
        end
        PH_DISCARD: begin
          if (fin) begin
            clear_chunk();
          end
        end
        default: begin
          clear_chunk();
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) begin
        $display("mismatch @%0t: %s", $time, msg);
      end
      mismatches++;
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
    endtask

    // Compare one output beat against the oldest expectation
    task check_result(pcsc_out_t got);
      pcsc_out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %b byte %h status %h",
                                  got.kind, got.data_byte, got.status));
        return;
      end
      want = expected_q.pop_front();
      cmp("kind", got.kind, want.kind);
      cmp("data_byte", got.data_byte, want.data_byte);
      cmp("status", got.status, want.status);
      cmp("chunk_length", got.chunk_length, want.chunk_length);
      cmp("chunk_type", got.chunk_type, want.chunk_type);
      cmp("type_valid", got.type_valid, want.type_valid);
      cmp("is_critical", got.is_critical, want.is_critical);
      cmp("is_private", got.is_private, want.is_private);
      cmp("is_reserved", got.is_reserved, want.is_reserved);
      cmp("is_safe_to_copy", got.is_safe_to_copy, want.is_safe_to_copy);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pcsc_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  pcsc_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_max_length;

  chunk_scoreboard sb;
  pcsc_in_t        stream_q[$];
  int unsigned     useful_bytes;
  int unsigned     tx_mode_left;
  bit              tx_calm;
  int unsigned     cycle_count;
  logic [30:0]     limit_list[4];

  png_chunk_stream_checker u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_length (cfg_max_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Stall the result side in random runs, with calm stretches
  initial begin
    int unsigned stall_run;
    int unsigned mode_left;
    bit          calm;
    out_stall = 1'b0;
    stall_run = 0;
    mode_left = 0;
    calm      = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 100);
      end
      mode_left--;
      if (stall_run == 0 && !calm) stall_run = pick_gap();
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted output beat
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_data);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Drive one beat, after a random gap, and hold it until accepted
  task automatic send_byte(pcsc_in_t it);
    int unsigned gap;
    if (tx_mode_left == 0) begin
      tx_calm      = ($urandom_range(0, 3) == 0);
      tx_mode_left = $urandom_range(20, 100);
    end
    tx_mode_left--;
    gap = tx_calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(it);
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Hold off input until every expected beat is out, then let the pipe settle
  task automatic drain();
    idle_input();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [30:0] v);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_max_length <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.len_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Queue one chunk; cut marks the byte where the stream ends early (-1 for none)
  task automatic queue_chunk(logic [31:0] len, logic [31:0] typ, bit good_crc, int cut,
                             bit end_last);
    logic [7:0]  raw[$];
    logic [31:0] crc;
    logic [7:0]  b;
    pcsc_in_t    it;
    crc = CRC_INIT;
    for (int k = 0; k < 4; k++) raw.push_back(len[31 - 8 * k -: 8]);
    for (int k = 0; k < 4; k++) begin
      b = typ[31 - 8 * k -: 8];
      raw.push_back(b);
      crc = chunk_scoreboard::crc32_update(crc, b);
    end
    for (int unsigned k = 0; k < len; k++) begin
      b = 8'($urandom);
      raw.push_back(b);
      crc = chunk_scoreboard::crc32_update(crc, b);
    end
    crc = ~crc;
    if (!good_crc) crc = crc ^ ($urandom | (32'h1 << $urandom_range(0, 31)));
    for (int k = 0; k < 4; k++) raw.push_back(crc[31 - 8 * k -: 8]);
    for (int k = 0; k < raw.size(); k++) begin
      it.in_byte    = raw[k];
      it.stream_end = (k == cut) || (end_last && k == raw.size() - 1);
      stream_q.push_back(it);
      useful_bytes++;
      if (k == cut) break;
    end
  endtask

  // Length over the limit, then junk up to the end of the stream unless it ends on the length
  task automatic queue_overlong(logic [31:0] len, bit end_at_len);
    pcsc_in_t    it;
    int unsigned n;
    for (int k = 0; k < 4; k++) begin
      it.in_byte    = len[31 - 8 * k -: 8];
      it.stream_end = end_at_len && (k == 3);
      stream_q.push_back(it);
    end
    useful_bytes += 4;
    if (!end_at_len) begin
      n = $urandom_range(0, 10);
      for (int unsigned k = 0; k <= n; k++) begin
        it.in_byte    = 8'($urandom);
        it.stream_end = (k == n);
        stream_q.push_back(it);
      end
    end
  endtask

  task automatic queue_noise();
    pcsc_in_t    it;
    int unsigned n;
    n = $urandom_range(1, 12);
    for (int unsigned k = 0; k < n; k++) begin
      it.in_byte    = 8'($urandom);
      it.stream_end = (k == n - 1);
      stream_q.push_back(it);
      useful_bytes++;
    end
  endtask

  function automatic logic [31:0] pick_overlong();
    logic [31:0] span;
    logic [31:0] x;
    span = 32'hffffffff - {1'b0, sb.len_limit};
    x    = $urandom_range(0, 1) ? $urandom_range(0, 3) : ($urandom % span);
    return {1'b0, sb.len_limit} + 32'd1 + x;
  endfunction

  // Well-formed chunk with random content, sometimes cut short or with a bad CRC
  task automatic queue_random_chunk();
    int unsigned cap;
    logic [31:0] len;
    logic [31:0] typ;
    logic [7:0]  c;
    int          cut;
    cap = (sb.len_limit < 24) ? sb.len_limit : 24;
    if ($urandom_range(0, 29) == 0) cap = (sb.len_limit < 300) ? sb.len_limit : 300;
    len = $urandom_range(0, cap);
    if ($urandom_range(0, 9) < 6) begin
      for (int k = 0; k < 4; k++) begin
        c = 8'd65 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) c = c + 8'd32;
        typ = {typ[23:0], c};
      end
    end else begin
      typ = $urandom;
    end
    cut = -1;
    if ($urandom_range(0, 99) < 15) cut = $urandom_range(0, 11 + len);
    queue_chunk(len, typ, $urandom_range(0, 3) != 0, cut, $urandom_range(0, 9) == 0);
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned r;
    useful_bytes = 0;
    while (useful_bytes < target) begin
      // Now and then let the block run dry before the next chunk
      if ($urandom_range(0, 24) == 0) begin
        idle_input();
        while (sb.outstanding() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_noise();
      end else if (r < 20) begin
        queue_overlong(pick_overlong(), $urandom_range(0, 3) == 0);
      end else begin
        queue_random_chunk();
      end
      send_stream();
    end
  endtask

  initial begin
    sb             = new();
    cycle_count    = 0;
    tx_mode_left   = 0;
    tx_calm        = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_max_length = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero-length letter chunk, bad CRC on odd type bytes,
    // longest length with the stream ending on it, stream ending in the length
    queue_chunk(32'd0, 32'h415a617a, 1'b1, -1, 1'b0);
    queue_chunk(32'd1, 32'h00ff7b40, 1'b0, -1, 1'b0);
    queue_overlong(32'hffffffff, 1'b1);
    queue_chunk(32'd0, 32'h49454e44, 1'b1, 1, 1'b0);
    send_stream();
    drain();

    // Random phases over a range of length limits, extremes included
    limit_list = '{31'd16, 31'd0, 31'h7fffffff, 31'($urandom_range(1, 40))};
    foreach (limit_list[i]) begin
      write_limit(limit_list[i]);
      random_phase(PHASE_BYTES);
      drain();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
